// ===== hw/rtl/rgbpo_pkg.sv =====
package rgbpo_pkg;

    // pixel and coordinate widths
    localparam int CoordW = 16;
    localparam int ChanW  = 8;

    typedef logic [CoordW-1:0] t_coord;
    typedef logic [ChanW-1:0]  t_chan;

    // configuration port: eight 32-bit registers at byte address 4*i
    localparam int CfgDataW = 32;
    localparam int CfgAddrW = 5;
    localparam int RegIdxW  = 3;

    typedef logic [RegIdxW-1:0] t_reg_idx;

    localparam t_reg_idx REG_OP_MODE   = 3'd0;
    localparam t_reg_idx REG_GAIN_RED  = 3'd1;
    localparam t_reg_idx REG_GAIN_GRN  = 3'd2;
    localparam t_reg_idx REG_GAIN_BLU  = 3'd3;
    localparam t_reg_idx REG_THRESHOLD = 3'd4;
    localparam t_reg_idx REG_WIN_X     = 3'd5;
    localparam t_reg_idx REG_WIN_Y     = 3'd6;
    localparam t_reg_idx REG_FILL      = 3'd7;

    typedef logic [2:0] t_op_mode;

    localparam t_op_mode MODE_AVG_GRAY   = 3'd0;
    localparam t_op_mode MODE_LUMA_GRAY  = 3'd1;
    localparam t_op_mode MODE_LIGHT_GRAY = 3'd2;
    localparam t_op_mode MODE_THRESHOLD  = 3'd3;
    localparam t_op_mode MODE_GAIN       = 3'd4;
    localparam t_op_mode MODE_INVERT     = 3'd5;
    localparam t_op_mode MODE_WIN_FILL   = 3'd6;

    // rec.709 weights in unsigned 0.16, summing to exactly 65536
    localparam logic [23:0] LUMA_WR = 24'd13933;
    localparam logic [23:0] LUMA_WG = 24'd46871;
    localparam logic [23:0] LUMA_WB = 24'd4732;

    // floor(s/3) == (s*683) >> 11 for every s up to 765
    localparam logic [9:0] DIV3_MUL   = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    localparam logic [15:0] GAIN_UNITY = 16'd256;
    localparam t_chan       THR_RESET  = 8'd128;
    localparam t_chan       CHAN_MAX   = 8'hFF;

endpackage

// ===== hw/rtl/rgbpo_if.sv =====
interface rgbpo_pix_in_if;
    logic               valid;
    logic               ready;
    rgbpo_pkg::t_coord  pix_x;
    rgbpo_pkg::t_coord  pix_y;
    rgbpo_pkg::t_chan   in_red;
    rgbpo_pkg::t_chan   in_green;
    rgbpo_pkg::t_chan   in_blue;
    rgbpo_pkg::t_chan   in_alpha;

    modport source (
        output valid, pix_x, pix_y, in_red, in_green, in_blue, in_alpha,
        input  ready
    );
    modport sink (
        input  valid, pix_x, pix_y, in_red, in_green, in_blue, in_alpha,
        output ready
    );
endinterface

interface rgbpo_pix_out_if;
    logic               valid;
    logic               ready;
    rgbpo_pkg::t_chan   out_red;
    rgbpo_pkg::t_chan   out_green;
    rgbpo_pkg::t_chan   out_blue;
    rgbpo_pkg::t_chan   out_alpha;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

// ===== hw/rtl/rgb_pixel_point_operations.sv =====
// pipeline: an accepted pixel is held in the input register, then in the result register,
//   which drives the output
// throughput: one pixel per clock while the output is ready; while a finished result waits
//   the input register takes one more beat, then the input stalls until the output moves
// reset: synchronous active-low i_rst_n empties both stages and loads the register
//   defaults (average gray, unity gains, threshold 128, empty window, black fill)
module rgb_pixel_point_operations (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rgbpo_pix_in_if.sink                    i_pix,
    rgbpo_pix_out_if.source                 o_pix,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rgbpo_pkg::CfgAddrW-1:0]  paddr,
    input  logic [rgbpo_pkg::CfgDataW-1:0]  pwdata,
    output logic [rgbpo_pkg::CfgDataW-1:0]  prdata,
    output logic                            pready
);
    import rgbpo_pkg::*;

    // configuration registers
    t_op_mode    r_op_mode;
    logic [15:0] r_gain_red;
    logic [15:0] r_gain_grn;
    logic [15:0] r_gain_blu;
    t_chan       r_threshold;
    logic [31:0] r_win_x;
    logic [31:0] r_win_y;
    logic [23:0] r_fill;

    // input stage
    logic   r_s1_vld;
    t_coord r_s1_x;
    t_coord r_s1_y;
    t_chan  r_s1_red;
    t_chan  r_s1_grn;
    t_chan  r_s1_blu;
    t_chan  r_s1_alp;

    // result stage
    logic   r_s2_vld;
    t_chan  r_s2_red;
    t_chan  r_s2_grn;
    t_chan  r_s2_blu;
    t_chan  r_s2_alp;
    t_chan  n_s2_red;
    t_chan  n_s2_grn;
    t_chan  n_s2_blu;

    logic     s1_rdy;
    logic     s2_rdy;
    logic     cfg_wr;
    t_reg_idx cfg_idx;

    logic [9:0]  rgb_sum;
    logic [19:0] avg_prod;
    t_chan       avg_gray;
    logic [23:0] luma_acc;
    t_chan       luma_gray;
    t_chan       ch_max;
    t_chan       ch_min;
    logic [8:0]  mm_sum;
    t_chan       light_gray;
    t_chan       thr_val;
    logic        in_window;

    // 8-bit channel times unsigned 8.8 gain, clipped to full scale
    function automatic t_chan gain_sat(input t_chan v, input logic [15:0] gn);
        logic [23:0] p;
        p = {16'd0, v} * {8'd0, gn};
        return (p[23:16] != 8'd0) ? CHAN_MAX : p[15:8];
    endfunction

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[CfgAddrW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode   <= MODE_AVG_GRAY;
            r_gain_red  <= GAIN_UNITY;
            r_gain_grn  <= GAIN_UNITY;
            r_gain_blu  <= GAIN_UNITY;
            r_threshold <= THR_RESET;
            r_win_x     <= '0;
            r_win_y     <= '0;
            r_fill      <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_OP_MODE:   r_op_mode   <= pwdata[2:0];
                REG_GAIN_RED:  r_gain_red  <= pwdata[15:0];
                REG_GAIN_GRN:  r_gain_grn  <= pwdata[15:0];
                REG_GAIN_BLU:  r_gain_blu  <= pwdata[15:0];
                REG_THRESHOLD: r_threshold <= pwdata[7:0];
                REG_WIN_X:     r_win_x     <= pwdata[31:0];
                REG_WIN_Y:     r_win_y     <= pwdata[31:0];
                REG_FILL:      r_fill      <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_OP_MODE:   prdata = {29'd0, r_op_mode};
            REG_GAIN_RED:  prdata = {16'd0, r_gain_red};
            REG_GAIN_GRN:  prdata = {16'd0, r_gain_grn};
            REG_GAIN_BLU:  prdata = {16'd0, r_gain_blu};
            REG_THRESHOLD: prdata = {24'd0, r_threshold};
            REG_WIN_X:     prdata = r_win_x;
            REG_WIN_Y:     prdata = r_win_y;
            REG_FILL:      prdata = {8'd0, r_fill};
            default:       prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    // each stage takes a new beat when empty or when its contents move on
    assign s2_rdy      = !r_s2_vld || o_pix.ready;
    assign s1_rdy      = !r_s1_vld || s2_rdy;
    assign i_pix.ready = s1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_vld <= i_pix.valid;
            end
            if (s2_rdy) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (s1_rdy && i_pix.valid) begin
            r_s1_x   <= i_pix.pix_x;
            r_s1_y   <= i_pix.pix_y;
            r_s1_red <= i_pix.in_red;
            r_s1_grn <= i_pix.in_green;
            r_s1_blu <= i_pix.in_blue;
            r_s1_alp <= i_pix.in_alpha;
        end
    end

    // ---------------- point operations ----------------
    // average gray, divide by three through a reciprocal multiply
    assign rgb_sum  = {2'd0, r_s1_red} + {2'd0, r_s1_grn} + {2'd0, r_s1_blu};
    assign avg_prod = {10'd0, rgb_sum} * {10'd0, DIV3_MUL};
    assign avg_gray = avg_prod[DIV3_SHIFT +: ChanW];

    // luminosity gray, weights sum to 1.0 so the top byte never overflows
    assign luma_acc  = {16'd0, r_s1_red} * LUMA_WR
                     + {16'd0, r_s1_grn} * LUMA_WG
                     + {16'd0, r_s1_blu} * LUMA_WB;
    assign luma_gray = luma_acc[23:16];

    // lightness gray, mean of the largest and smallest channel
    always_comb begin
        ch_max = r_s1_red;
        ch_min = r_s1_red;
        if (r_s1_grn > ch_max) ch_max = r_s1_grn;
        if (r_s1_blu > ch_max) ch_max = r_s1_blu;
        if (r_s1_grn < ch_min) ch_min = r_s1_grn;
        if (r_s1_blu < ch_min) ch_min = r_s1_blu;
    end
    assign mm_sum     = {1'b0, ch_max} + {1'b0, ch_min};
    assign light_gray = mm_sum[8:1];

    assign thr_val = (avg_gray > r_threshold) ? CHAN_MAX : '0;

    // all bounds exclusive; an empty or inverted window fills every pixel
    assign in_window = (r_s1_x > r_win_x[15:0]) && (r_s1_x < r_win_x[31:16]) &&
                       (r_s1_y > r_win_y[15:0]) && (r_s1_y < r_win_y[31:16]);

    always_comb begin
        n_s2_red = r_s1_red;
        n_s2_grn = r_s1_grn;
        n_s2_blu = r_s1_blu;
        case (r_op_mode)
            MODE_AVG_GRAY: begin
                n_s2_red = avg_gray;
                n_s2_grn = avg_gray;
                n_s2_blu = avg_gray;
            end
            MODE_LUMA_GRAY: begin
                n_s2_red = luma_gray;
                n_s2_grn = luma_gray;
                n_s2_blu = luma_gray;
            end
            MODE_LIGHT_GRAY: begin
                n_s2_red = light_gray;
                n_s2_grn = light_gray;
                n_s2_blu = light_gray;
            end
            MODE_THRESHOLD: begin
                n_s2_red = thr_val;
                n_s2_grn = thr_val;
                n_s2_blu = thr_val;
            end
            MODE_GAIN: begin
                n_s2_red = gain_sat(r_s1_red, r_gain_red);
                n_s2_grn = gain_sat(r_s1_grn, r_gain_grn);
                n_s2_blu = gain_sat(r_s1_blu, r_gain_blu);
            end
            MODE_INVERT: begin
                n_s2_red = ~r_s1_red;
                n_s2_grn = ~r_s1_grn;
                n_s2_blu = ~r_s1_blu;
            end
            MODE_WIN_FILL: begin
                if (!in_window) begin
                    n_s2_red = r_fill[7:0];
                    n_s2_grn = r_fill[15:8];
                    n_s2_blu = r_fill[23:16];
                end
            end
            // unused mode code passes the pixel through
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (s2_rdy && r_s1_vld) begin
            r_s2_red <= n_s2_red;
            r_s2_grn <= n_s2_grn;
            r_s2_blu <= n_s2_blu;
            r_s2_alp <= r_s1_alp;
        end
    end

    assign o_pix.valid     = r_s2_vld;
    assign o_pix.out_red   = r_s2_red;
    assign o_pix.out_green = r_s2_grn;
    assign o_pix.out_blue  = r_s2_blu;
    assign o_pix.out_alpha = r_s2_alp;

endmodule

// ===== hw/rtl/rgbpo_checker.sv =====
module rgbpo_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [rgbpo_pkg::ChanW-1:0] i_out_red,
    input logic [rgbpo_pkg::ChanW-1:0] i_out_green,
    input logic [rgbpo_pkg::ChanW-1:0] i_out_blue,
    input logic [rgbpo_pkg::ChanW-1:0] i_out_alpha
);
    import rgbpo_pkg::*;

    // nothing comes out of reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output beat valid right after reset");

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_red) &&
            $stable(i_out_green) && $stable(i_out_blue) && $stable(i_out_alpha))
        else $error("stalled output beat changed");

    // with the output drained the input cannot be blocked
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // an accepted beat passes the input and result registers to the output when not stalled
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 i_out_ready |=> i_out_valid)
        else $error("accepted beat did not reach the output");

endmodule

bind rgb_pixel_point_operations rgbpo_checker u_rgbpo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_red   (o_pix.out_red),
    .i_out_green (o_pix.out_green),
    .i_out_blue  (o_pix.out_blue),
    .i_out_alpha (o_pix.out_alpha)
);
